// ===== hdl/sspq_pkg.sv =====
// Shared types and constants for the stable sorted priority queue.
package sspq_pkg;

	localparam int unsigned CAPACITY_DEF = 16;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_FULL  = 2'd1,
		ST_DEQ   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [63:0] name_a;
		logic [63:0] name_b;
		logic [31:0] name_c;
		logic [7:0]  age;
		logic [7:0]  prio;
	} rec_t;

	typedef struct packed {
		logic enq;
		logic deq;
		logic valid;
		logic left_place;
	} cell_ctl_t;

endpackage

// ===== hdl/sspq_cell.sv =====
// One slot of the sorted chain: holds a record, shifts right on insert, left on removal.
module sspq_cell (
	input  logic              clk,
	input  sspq_pkg::cell_ctl_t ctl,
	input  sspq_pkg::rec_t    in_rec,
	input  sspq_pkg::rec_t    left_rec,
	input  sspq_pkg::rec_t    right_rec,
	output sspq_pkg::rec_t    rec,
	output logic              place
);
	import sspq_pkg::*;

	rec_t rec_q;

	// New record belongs at or before this slot.
	assign place = !ctl.valid || (rec_q.prio > in_rec.prio);
	assign rec   = rec_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && place) begin
			rec_q <= ctl.left_place ? left_rec : in_rec;
		end else if (ctl.deq) begin
			rec_q <= right_rec;
		end
	end

endmodule

// ===== hdl/stable_sorted_priority_queue_top.sv =====
// Top level of the stable sorted priority queue: a chain of record cells and a count.
//
// Usage:
//   Command channel: raise start with mode and the record fields; the
//   transaction is taken at a rising edge with start high and busy low.
//   busy stays low, so a new transaction can be taken in every cycle.
//   mode enqueue inserts the record after all held records of equal or
//   smaller priority; mode dequeue removes and returns the head record.
//   Result channel: in the cycle after each transaction, done is high for
//   exactly one cycle with status, the removed record (zero unless a
//   record was removed) and the occupancy after the transaction.
//   Throughput 1 transaction per cycle: every cell compares its priority
//   with the new one and shifts in the cycle the transaction is taken.
//   Reset clears the count, so the queue comes up empty; slot contents
//   need no clearing. The receiver cannot stall: each result is shown
//   for one cycle only and must be taken then.
module stable_sorted_priority_queue_top #(
	parameter int unsigned CAPACITY = sspq_pkg::CAPACITY_DEF,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [63:0]       name_a,
	input  logic [63:0]       name_b,
	input  logic [31:0]       name_c,
	input  logic [7:0]        age,
	input  logic [7:0]        priority_req,
	output logic              done,
	output logic [1:0]        status,
	output logic [63:0]       out_name_a,
	output logic [63:0]       out_name_b,
	output logic [31:0]       out_name_c,
	output logic [7:0]        out_age,
	output logic [7:0]        out_priority,
	output logic [CNT_W-1:0]  occupancy
);
	import sspq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	status_t          status_q;
	rec_t             out_rec_q;

	rec_t             in_rec;
	rec_t             cell_rec [CAPACITY];
	logic [CAPACITY-1:0] cell_place;
	logic             accept;
	logic             full;
	logic             empty;
	logic             enq_ok;
	logic             deq_ok;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign enq_ok = accept && (mode == MODE_ENQ) && !full;
	assign deq_ok = accept && (mode == MODE_DEQ) && !empty;

	assign in_rec = '{name_a: name_a, name_b: name_b, name_c: name_c,
		age: age, prio: priority_req};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		rec_t      left_rec;
		rec_t      right_rec;

		if (i == 0) begin : g_first
			assign ctl.left_place = 1'b0;
			assign left_rec       = in_rec;
		end else begin : g_mid
			assign ctl.left_place = cell_place[i-1];
			assign left_rec       = cell_rec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_rec = cell_rec[i];
		end else begin : g_inner
			assign right_rec = cell_rec[i+1];
		end

		assign ctl.enq   = enq_ok;
		assign ctl.deq   = deq_ok;
		assign ctl.valid = (count_q > CNT_W'(i));

		sspq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.in_rec    (in_rec),
			.left_rec  (left_rec),
			.right_rec (right_rec),
			.rec       (cell_rec[i]),
			.place     (cell_place[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_ENQ;
		end else begin
			done_q <= accept;
			if (enq_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (deq_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				if (mode == MODE_ENQ) begin
					status_q <= full ? ST_FULL : ST_ENQ;
				end else begin
					status_q <= empty ? ST_EMPTY : ST_DEQ;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_rec_q <= deq_ok ? cell_rec[0] : '0;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign out_name_a   = out_rec_q.name_a;
	assign out_name_b   = out_rec_q.name_b;
	assign out_name_c   = out_rec_q.name_c;
	assign out_age      = out_rec_q.age;
	assign out_priority = out_rec_q.prio;
	assign occupancy    = count_q;

endmodule

// ===== hdl/sspq_checker.sv =====
// Port-level checks for the stable sorted priority queue, bound to the top level.
module sspq_checker #(
	parameter int unsigned CAPACITY = sspq_pkg::CAPACITY_DEF,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [1:0]        status,
	input logic [63:0]       out_name_a,
	input logic [63:0]       out_name_b,
	input logic [31:0]       out_name_c,
	input logic [7:0]        out_age,
	input logic [7:0]        out_priority,
	input logic [CNT_W-1:0]  occupancy
);
	import sspq_pkg::*;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transaction without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without transaction");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == CNT_W'(CAPACITY)))
		else $error("drop reported while not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (occupancy == '0))
		else $error("empty reported with entries held");

	a_zero_record: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DEQ) |-> (out_name_a == '0 && out_name_b == '0 &&
		out_name_c == '0 && out_age == '0 && out_priority == '0))
		else $error("record fields not zero without removal");

endmodule

bind stable_sorted_priority_queue_top sspq_checker #(.CAPACITY(CAPACITY)) u_sspq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.out_name_a   (out_name_a),
	.out_name_b   (out_name_b),
	.out_name_c   (out_name_c),
	.out_age      (out_age),
	.out_priority (out_priority),
	.occupancy    (occupancy)
);

// ===== dv/tb_stable_sorted_priority_queue_top.sv =====
// Testbench for the stable sorted priority queue: directed table, random traffic, predictor.
module tb_stable_sorted_priority_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sspq_pkg::*;

	localparam int DEPTH = CAPACITY_DEF;
	localparam int PHASE_ITEMS = 475;

	typedef struct packed {
		status_t     status;
		rec_t        rec;
		logic [4:0]  occ;
	} result_t;

	typedef struct packed {
		logic     mode;
		rec_t     rec;
		logic     typed;
		result_t  exp;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [63:0] name_a;
	logic [63:0] name_b;
	logic [31:0] name_c;
	logic [7:0]  age;
	logic [7:0]  priority_req;
	logic        done;
	logic [1:0]  status;
	logic [63:0] out_name_a;
	logic [63:0] out_name_b;
	logic [31:0] out_name_c;
	logic [7:0]  out_age;
	logic [7:0]  out_priority;
	logic [4:0]  occupancy;

	logic        row_typed;
	result_t     row_exp;

	rec_t        held [DEPTH];
	int          held_cnt = 0;
	result_t     pending_results [$];
	step_row_t   dir_rows [$];
	int          idle_pct = 0;
	int          err_cnt = 0;
	int          n_enq = 0, n_full = 0, n_deq = 0, n_empty = 0, n_hit_full = 0;

	stable_sorted_priority_queue_top uut (.*);

	always #10 clk = ~clk;

	// Insert after equal priorities, serve from slot 0.
	function automatic result_t queue_apply(input logic m, input rec_t r);
		result_t res;
		int      pos;
		res = '0;
		if (m == MODE_ENQ) begin
			if (held_cnt >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_cnt && held[pos].prio <= r.prio)
					pos++;
				for (int k = held_cnt; k > pos; k--)
					held[k] = held[k-1];
				held[pos] = r;
				held_cnt++;
				res.status = ST_ENQ;
			end
		end else if (held_cnt == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.status = ST_DEQ;
			res.rec = held[0];
			for (int k = 1; k < held_cnt; k++)
				held[k-1] = held[k];
			held_cnt--;
		end
		res.occ = held_cnt[4:0];
		return res;
	endfunction

	task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, actual %0h", nm, e, a);
			err_cnt++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t pred;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result with no transaction outstanding");
					err_cnt++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 64'(want.status), 64'(status));
					check_field("out_name_a", want.rec.name_a, out_name_a);
					check_field("out_name_b", want.rec.name_b, out_name_b);
					check_field("out_name_c", 64'(want.rec.name_c), 64'(out_name_c));
					check_field("out_age", 64'(want.rec.age), 64'(out_age));
					check_field("out_priority", 64'(want.rec.prio), 64'(out_priority));
					check_field("occupancy", 64'(want.occ), 64'(occupancy));
				end
			end
			if (start && !busy) begin
				pred = queue_apply(mode, {name_a, name_b, name_c, age, priority_req});
				case (pred.status)
					ST_ENQ: begin
						n_enq++;
						if (pred.occ == DEPTH)
							n_hit_full++;
					end
					ST_FULL:  n_full++;
					ST_DEQ:   n_deq++;
					ST_EMPTY: n_empty++;
					default:  ;
				endcase
				pending_results.push_back(row_typed ? row_exp : pred);
			end
		end
	end

	function automatic step_row_t mk_row(input logic m, input rec_t r, input logic typed,
			input result_t e);
		step_row_t row;
		row.mode = m;
		row.rec = r;
		row.typed = typed;
		row.exp = e;
		return row;
	endfunction

	function automatic step_row_t rand_row(input int enq_pct);
		rec_t r;
		r.name_a = {$urandom, $urandom};
		r.name_b = {$urandom, $urandom};
		r.name_c = $urandom;
		r.age = 8'($urandom_range(255));
		case ($urandom_range(3))
			0: r.prio = 8'($urandom_range(255));
			1: r.prio = 8'($urandom_range(3));
			2: r.prio = 8'hFC + 8'($urandom_range(3));
			default: r.prio = $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
		return mk_row(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ, r, 1'b0, '0);
	endfunction

	task automatic issue(input step_row_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mode <= r.mode;
		name_a <= r.rec.name_a;
		name_b <= r.rec.name_b;
		name_c <= r.rec.name_c;
		age <= r.rec.age;
		priority_req <= r.rec.prio;
		row_typed <= r.typed;
		row_exp <= r.exp;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		rec_t  ones_r;
		rec_t  zero_r;
		rec_t  r;
		int    enq_pct;
		int    wait_cnt;
		int    pct_pick [5] = '{10, 25, 50, 75, 90};
		int    phase_idle [3] = '{19, 62, 0};

		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ENQ;
		name_a = '0;
		name_b = '0;
		name_c = '0;
		age = '0;
		priority_req = '0;
		row_typed = 1'b0;
		row_exp = '0;

		ones_r = '1;
		ones_r.prio = 8'h00;
		zero_r = '0;
		zero_r.prio = 8'hFF;

		dir_rows.push_back(mk_row(MODE_DEQ, ones_r, 1'b1, '{ST_EMPTY, '0, 5'd0}));
		dir_rows.push_back(mk_row(MODE_ENQ, ones_r, 1'b1, '{ST_ENQ, '0, 5'd1}));
		dir_rows.push_back(mk_row(MODE_ENQ, zero_r, 1'b1, '{ST_ENQ, '0, 5'd2}));
		dir_rows.push_back(mk_row(MODE_DEQ, zero_r, 1'b1, '{ST_DEQ, ones_r, 5'd1}));
		dir_rows.push_back(mk_row(MODE_DEQ, ones_r, 1'b0, '0));
		dir_rows.push_back(mk_row(MODE_DEQ, zero_r, 1'b1, '{ST_EMPTY, '0, 5'd0}));
		// fill with two interleaved priority levels; checks arrival order within a level
		for (int i = 0; i < DEPTH; i++) begin
			r.name_a = {8{8'(i)}};
			r.name_b = 64'h0123_4567_89AB_CDEF ^ {16{4'(i)}};
			r.name_c = 32'hA5A5_0000 | i;
			r.age = 8'(i * 17);
			r.prio = (i % 3 == 0) ? 8'h40 : 8'h20;
			dir_rows.push_back(mk_row(MODE_ENQ, r, i == DEPTH - 1,
				'{ST_ENQ, '0, 5'(i + 1)}));
		end
		dir_rows.push_back(mk_row(MODE_ENQ, ones_r, 1'b1, '{ST_FULL, '0, 5'(DEPTH)}));
		dir_rows.push_back(mk_row(MODE_DEQ, zero_r, 1'b0, '0));
		dir_rows.push_back(mk_row(MODE_ENQ, zero_r, 1'b0, '0));

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i]);

		for (int p = 0; p < 3; p++) begin
			drain_results();
			idle_pct = phase_idle[p];
			enq_pct = 50;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 30 == 0)
					enq_pct = pct_pick[$urandom_range(4)];
				issue(rand_row(enq_pct));
			end
		end

		start <= 1'b0;
		@(negedge clk);
		wait_cnt = 0;
		while (pending_results.size() != 0 && wait_cnt < 100) begin
			@(negedge clk);
			wait_cnt++;
		end
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			err_cnt++;
		end
		repeat (4) @(negedge clk);

		$display("transactions: %0d enqueued, %0d dropped on full, %0d dequeued, %0d on empty",
			n_enq, n_full, n_deq, n_empty);
		$display("queue filled to capacity %0d times; %0d mismatches", n_hit_full, err_cnt);
		if (err_cnt == 0)
			$display("tb_stable_sorted_priority_queue_top: clean");
		else
			$display("tb_stable_sorted_priority_queue_top: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_stable_sorted_priority_queue_top: errors");
		$finish;
	end

endmodule
